// File: sv/uef_pkg.sv
// ----------------------------------------------------------------------------
// uef_pkg
// Shared types and codes for the utf-8 escape filter.
// ----------------------------------------------------------------------------
package uef_pkg;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LEAD = 2'd1;
  localparam logic [1:0] ST_BAD_CONT = 2'd2;
  localparam logic [1:0] ST_TRUNC    = 2'd3;

  // work kinds handed from front to back
  localparam logic [1:0] KIND_CHAR   = 2'd0;
  localparam logic [1:0] KIND_ESC    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;

  // one classified input item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] chr;
    logic [1:0] status;
    logic [1:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } work_t;

  typedef struct packed {
    logic  valid;
    work_t work;
  } work_push_t;

  typedef struct packed {
    logic  valid;
    work_t work;
  } work_head_t;

endpackage

// File: sv/uef_if.sv
// ----------------------------------------------------------------------------
// uef channel interfaces
// Byte input channel and character result channel with valid/ready.
// ----------------------------------------------------------------------------
interface uef_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface uef_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output out_char, output char_valid, output status,
                  output last, input ready);
  modport sink   (input valid, input out_char, input char_valid, input status,
                  input last, output ready);
endinterface

// File: sv/uef_front.sv
// ----------------------------------------------------------------------------
// uef_front
// Accepts input beats, tracks the utf-8 sequence state and classifies each
// byte into a work entry with its decimal digits precomputed.
// ----------------------------------------------------------------------------
module uef_front
  import uef_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  uef_byte_if.sink   stream,
  output work_push_t push,
  input  logic       push_ready
);

  logic [1:0]  bytes_remaining;
  logic [1:0]  bytes_remaining_next;
  logic        halted;
  logic        halted_next;
  logic        accept;
  logic [7:0]  b;
  logic [1:0]  hund;
  logic [7:0]  rem;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [7:0]  ones_full;
  work_t       work;
  logic        emit;

  // a halted block swallows every beat
  assign stream.ready = halted | push_ready;
  assign accept       = stream.valid & stream.ready;
  assign b            = stream.in_byte;

  // decimal split: hundreds by compare, tens by reciprocal (exact below 180)
  always_comb begin
    if (b >= 8'd200) begin
      hund = 2'd2;
      rem  = b - 8'd200;
    end else if (b >= 8'd100) begin
      hund = 2'd1;
      rem  = b - 8'd100;
    end else begin
      hund = 2'd0;
      rem  = b;
    end
    tens_prod = {8'd0, rem[6:0]} * 15'd205;
    tens      = tens_prod[14:11];
    ones_full = rem - ({4'd0, tens} * 8'd10);
  end

  always_comb begin
    bytes_remaining_next = bytes_remaining;
    halted_next          = halted;
    emit                 = 1'b0;
    work.kind            = KIND_ESC;
    work.chr             = b;
    work.status          = ST_OK;
    work.hund            = hund;
    work.tens            = tens;
    work.ones            = ones_full[3:0];
    if (accept && !halted) begin
      emit = 1'b1;
      if (stream.end_of_stream) begin
        work.kind = KIND_STATUS;
        if (bytes_remaining != 2'd0) begin
          work.status = ST_TRUNC;
          halted_next = 1'b1;
        end
      end else if (bytes_remaining != 2'd0) begin
        if (b[7:6] != 2'b10) begin
          work.kind   = KIND_STATUS;
          work.status = ST_BAD_CONT;
          halted_next = 1'b1;
        end else begin
          bytes_remaining_next = bytes_remaining - 2'd1;
        end
      end else if (!b[7]) begin
        work.kind = KIND_CHAR;
      end else if (b[7:5] == 3'b110) begin
        bytes_remaining_next = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        bytes_remaining_next = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        bytes_remaining_next = 2'd3;
      end else begin
        work.kind   = KIND_STATUS;
        work.status = ST_BAD_LEAD;
        halted_next = 1'b1;
      end
    end
  end

  assign push.valid = emit;
  assign push.work  = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= 2'd0;
      halted          <= 1'b0;
    end else begin
      bytes_remaining <= bytes_remaining_next;
      halted          <= halted_next;
    end
  end

endmodule

// File: sv/uef_queue.sv
// ----------------------------------------------------------------------------
// uef_queue
// Two-entry queue of work entries between the front and back parts.
// ----------------------------------------------------------------------------
module uef_queue
  import uef_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  work_push_t push,
  output logic       push_ready,
  output work_head_t head,
  input  logic       pop
);

  work_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign head.valid = (count != 2'd0);
  assign head.work  = mem[rd_ptr];
  assign do_push    = push.valid & push_ready;
  assign do_pop     = pop & head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.work;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/uef_back.sv
// ----------------------------------------------------------------------------
// uef_back
// Expands queued work into result beats, one per cycle while result.ready
// is high, through a registered output stage.
// ----------------------------------------------------------------------------
module uef_back
  import uef_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  work_head_t head,
  output logic       pop,
  uef_char_if.source result
);

  logic       out_valid;
  logic [7:0] out_char;
  logic       char_valid;
  logic [1:0] status;
  logic       last;
  logic [1:0] phase;
  logic       load;
  logic [7:0] beat_char;
  logic       beat_char_valid;
  logic [1:0] beat_status;
  logic       beat_last;
  logic       beat_done;

  assign load = head.valid & (~out_valid | result.ready);
  assign pop  = load & beat_done;

  always_comb begin
    beat_char       = 8'd0;
    beat_char_valid = 1'b1;
    beat_status     = ST_OK;
    beat_last       = 1'b1;
    beat_done       = 1'b1;
    unique case (head.work.kind)
      KIND_CHAR: begin
        beat_char = head.work.chr;
      end
      KIND_ESC: begin
        beat_last = (phase == 2'd3);
        beat_done = (phase == 2'd3);
        unique case (phase)
          2'd0:    beat_char = CHAR_BSLASH;
          2'd1:    beat_char = CHAR_ZERO + {6'd0, head.work.hund};
          2'd2:    beat_char = CHAR_ZERO + {4'd0, head.work.tens};
          default: beat_char = CHAR_ZERO + {4'd0, head.work.ones};
        endcase
      end
      default: begin
        beat_char_valid = 1'b0;
        beat_status     = head.work.status;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char   <= beat_char;
      char_valid <= beat_char_valid;
      status     <= beat_status;
      last       <= beat_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        phase <= beat_done ? 2'd0 : phase + 2'd1;
      end
    end
  end

  assign result.valid      = out_valid;
  assign result.out_char   = out_char;
  assign result.char_valid = char_valid;
  assign result.status     = status;
  assign result.last       = last;

endmodule

// File: sv/utf8_escape_filter.sv
// ----------------------------------------------------------------------------
// utf8_escape_filter
// Checks utf-8 structure of a byte stream and escapes non-ascii bytes as
// a backslash plus three decimal digits.
// ----------------------------------------------------------------------------
// stream: one input beat per byte, or an end_of_stream marker
// result: one beat per output character or status; last marks the final
//   beat produced by an input beat
// ascii byte gives one beat, a lead or continuation byte gives four beats,
// an error or end marker gives one status beat (char_valid low)
// a beat is classified in the cycle it is accepted, is written into the
//   two-entry queue, and its first result is then loaded into the output register
// throughput: one result beat per cycle while result.ready is high, set by the
//   output register, so an escaped byte takes four result beats and an ascii byte one
// the input keeps accepting while the queue has room, so stalls on result
//   back up through the queue to stream.ready
// after an error the block drops every input beat until reset
// reset clears the sequence state, the halt flag, the queue and the output
// ----------------------------------------------------------------------------
module utf8_escape_filter
  import uef_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  uef_byte_if.sink     stream,
  uef_char_if.source   result
);

  work_push_t push;
  logic       push_ready;
  work_head_t head;
  logic       pop;

  uef_front u_front (
    .clk        (clk),
    .rst        (rst),
    .stream     (stream),
    .push       (push),
    .push_ready (push_ready)
  );

  uef_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .head       (head),
    .pop        (pop)
  );

  uef_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule
